// ----- rtl/fsp_pkg.sv -----
// shared types, character codes and helpers for the format spec parser
package fsp_pkg;

    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_LOW_H = 8'h68;
    localparam logic [7:0] CH_LOW_L = 8'h6C;
    localparam logic [7:0] CH_LOW_J = 8'h6A;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_L  = 8'h4C;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    localparam int FLAG_W = 5;
    localparam int LEN_W  = 7;
    localparam int NUM_W  = 31;

    localparam logic [NUM_W-1:0] SAT31 = {NUM_W{1'b1}};

    // flag bit positions
    localparam int FB_SHARP = 0;
    localparam int FB_ZERO  = 1;
    localparam int FB_MINUS = 2;
    localparam int FB_PLUS  = 3;
    localparam int FB_SPACE = 4;

    // length bit positions
    localparam int LB_HH = 0;
    localparam int LB_H  = 1;
    localparam int LB_LL = 2;
    localparam int LB_L  = 3;
    localparam int LB_J  = 4;
    localparam int LB_Z  = 5;
    localparam int LB_BL = 6;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_FLAGS1,
        PH_WSTAR,
        PH_WDIG,
        PH_PSTART,
        PH_PDIG,
        PH_LEN,
        PH_FLAGS2
    } t_phase;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_H,
        PEND_L
    } t_pend;

    typedef struct packed {
        logic [FLAG_W-1:0] flag;
        logic              star;
        logic              digit;
        logic [3:0]        dig;
        logic              dot;
        logic              low_h;
        logic              low_l;
        logic              low_j;
        logic              low_z;
        logic              up_l;
        logic              skip;
        logic              upper;
    } t_cls;

    typedef struct packed {
        logic [7:0]       ch;
        t_cls             cls;
        logic             star_neg;
        logic [NUM_W-1:0] star_abs;
    } t_item;

    typedef struct packed {
        logic [7:0]        conv_char;
        logic [FLAG_W-1:0] flag_bits;
        logic [NUM_W-1:0]  field_width;
        logic              has_precision;
        logic [NUM_W-1:0]  precision_value;
        logic              neg_star_prec;
        logic [LEN_W-1:0]  length_bits;
        logic              upper_conv;
    } t_rec;

    function automatic logic [FLAG_W-1:0] flag_bit(input logic [7:0] c);
        logic [FLAG_W-1:0] f;
        f = '0;
        case (c)
            CH_SHARP: f[FB_SHARP] = 1'b1;
            CH_ZERO:  f[FB_ZERO]  = 1'b1;
            CH_MINUS: f[FB_MINUS] = 1'b1;
            CH_PLUS:  f[FB_PLUS]  = 1'b1;
            CH_SPACE: f[FB_SPACE] = 1'b1;
            default:  f = '0;
        endcase
        return f;
    endfunction

    // acc * 10 + digit, saturating
    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [NUM_W+3:0] t;
        t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUM_W+4)'(d);
        return (t > (NUM_W+4)'(SAT31)) ? SAT31 : t[NUM_W-1:0];
    endfunction

endpackage

// ----- rtl/fsp_if.sv -----
// valid/ready channel interfaces for spec bytes and spec records
interface fsp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_byte;
    logic signed [31:0] star_value;

    modport source (output valid, output char_byte, output star_value, input ready);
    modport sink   (input valid, input char_byte, input star_value, output ready);
endinterface

interface fsp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  conv_char;
    logic [4:0]  flag_bits;
    logic [30:0] field_width;
    logic        has_precision;
    logic [30:0] precision_value;
    logic        neg_star_prec;
    logic [6:0]  length_bits;
    logic        upper_conv;

    modport source (
        output valid, output conv_char, output flag_bits, output field_width,
        output has_precision, output precision_value, output neg_star_prec,
        output length_bits, output upper_conv, input ready
    );
    modport sink (
        input valid, input conv_char, input flag_bits, input field_width,
        input has_precision, input precision_value, input neg_star_prec,
        input length_bits, input upper_conv, output ready
    );
endinterface

// ----- rtl/fsp_front.sv -----
// front end: classifies each input byte and resolves the star argument
module fsp_front (
    input  logic [7:0]    i_char_byte,
    input  logic [31:0]   i_star_value,
    output fsp_pkg::t_item o_item
);
    import fsp_pkg::*;

    logic [31:0] mag;

    always_comb begin
        mag = ~i_star_value + 32'd1;

        o_item.ch           = i_char_byte;
        o_item.cls.flag     = flag_bit(i_char_byte);
        o_item.cls.star     = (i_char_byte == CH_STAR);
        o_item.cls.digit    = (i_char_byte >= CH_ZERO) && (i_char_byte <= CH_NINE);
        o_item.cls.dig      = i_char_byte[3:0];
        o_item.cls.dot      = (i_char_byte == CH_DOT);
        o_item.cls.low_h    = (i_char_byte == CH_LOW_H);
        o_item.cls.low_l    = (i_char_byte == CH_LOW_L);
        o_item.cls.low_j    = (i_char_byte == CH_LOW_J);
        o_item.cls.low_z    = (i_char_byte == CH_LOW_Z);
        o_item.cls.up_l     = (i_char_byte == CH_UP_L);
        o_item.cls.skip     = (i_char_byte == CH_DOT) || (i_char_byte == CH_ONE)
                              || (i_char_byte == CH_TWO);
        o_item.cls.upper    = (i_char_byte >= CH_UP_A) && (i_char_byte <= CH_UP_Z);

        // magnitude of a negative argument, most negative saturates
        o_item.star_neg = i_star_value[31];
        if (i_star_value[31]) begin
            o_item.star_abs = mag[31] ? SAT31 : mag[NUM_W-1:0];
        end else begin
            o_item.star_abs = i_star_value[NUM_W-1:0];
        end
    end

endmodule

// ----- rtl/fsp_queue.sv -----
// short fifo of classified beats between front and back
module fsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  fsp_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output fsp_pkg::t_item o_pop_item,
    input  logic           i_pop_ready
);
    import fsp_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;
    logic            push, pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/fsp_back.sv -----
// back end: phase machine, accumulators and the record output register
module fsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  fsp_pkg::t_item i_item,
    output logic           o_item_ready,
    fsp_out_if.source      o_out
);
    import fsp_pkg::*;

    t_phase            r_phase, n_phase;
    t_pend             r_pend, n_pend;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic [NUM_W-1:0]  r_width, n_width;
    logic [NUM_W-1:0]  r_prec, n_prec;
    logic              r_prec_seen, n_prec_seen;
    logic              r_neg_star, n_neg_star;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_out_valid, n_out_valid;
    t_rec              r_rec, n_rec;

    logic              take, emit, stop;
    logic              fall_dot, fall_pstart, fall_pdig, fall_len, fall_f2;
    logic [FLAG_W-1:0] fres;
    t_cls              k;

    assign o_item_ready = !r_out_valid || o_out.ready;
    assign take         = i_item_valid && o_item_ready;
    assign k            = i_item.cls;

    always_comb begin
        n_phase     = r_phase;
        n_pend      = r_pend;
        n_flags     = r_flags;
        n_width     = r_width;
        n_prec      = r_prec;
        n_prec_seen = r_prec_seen;
        n_neg_star  = r_neg_star;
        n_len       = r_len;
        n_rec       = r_rec;
        n_out_valid = r_out_valid && !o_out.ready;
        emit        = 1'b0;
        stop        = 1'b0;
        fall_dot    = 1'b0;
        fall_pstart = 1'b0;
        fall_pdig   = 1'b0;
        fall_len    = 1'b0;
        fall_f2     = 1'b0;
        fres        = '0;

        if (take) begin
            case (r_phase)
                PH_FLAGS1: begin
                    if (k.flag != '0) begin
                        n_flags = r_flags | k.flag;
                    end else if (k.star) begin
                        if (i_item.star_neg) begin
                            n_flags[FB_MINUS] = 1'b1;
                        end
                        n_width = i_item.star_abs;
                        n_phase = PH_WSTAR;
                    end else if (k.digit) begin
                        n_width = NUM_W'(k.dig);
                        n_phase = PH_WDIG;
                    end else begin
                        fall_dot = 1'b1;
                    end
                end
                PH_WSTAR, PH_WDIG: begin
                    if (k.digit) begin
                        n_width = (r_phase == PH_WSTAR) ? NUM_W'(k.dig)
                                                        : add_digit(r_width, k.dig);
                        n_phase = PH_WDIG;
                    end else begin
                        fall_dot = 1'b1;
                    end
                end
                PH_PSTART: fall_pstart = 1'b1;
                PH_PDIG:   fall_pdig   = 1'b1;
                PH_LEN:    fall_len    = 1'b1;
                PH_FLAGS2: fall_f2     = 1'b1;
                default:   fall_f2     = 1'b1;
            endcase

            if (fall_dot) begin
                if (k.dot) begin
                    n_prec_seen = 1'b1;
                    n_phase     = PH_PSTART;
                end else begin
                    fall_len = 1'b1;
                end
            end

            if (fall_pstart) begin
                if (k.star) begin
                    if (i_item.star_neg) begin
                        n_prec     = '0;
                        n_neg_star = 1'b1;
                    end else begin
                        n_prec = i_item.star_abs;
                    end
                    n_phase = PH_LEN;
                end else if (k.digit) begin
                    n_prec  = NUM_W'(k.dig);
                    n_phase = PH_PDIG;
                end else begin
                    fall_len = 1'b1;
                end
            end

            if (fall_pdig) begin
                if (k.digit) begin
                    n_prec = add_digit(r_prec, k.dig);
                end else begin
                    fall_len = 1'b1;
                end
            end

            if (fall_len) begin
                n_pend = PEND_NONE;
                case (r_pend)
                    PEND_H: begin
                        if (k.low_h) begin
                            n_len[LB_HH] = 1'b1;
                            stop         = 1'b1;
                        end else begin
                            n_len[LB_H] = 1'b1;
                        end
                    end
                    PEND_L: begin
                        if (k.low_l) begin
                            n_len[LB_LL] = 1'b1;
                            stop         = 1'b1;
                        end else begin
                            n_len[LB_L] = 1'b1;
                        end
                    end
                    default: ;
                endcase
                n_phase = PH_LEN;
                if (!stop) begin
                    if (k.low_h) begin
                        n_pend = PEND_H;
                    end else if (k.low_l) begin
                        n_pend = PEND_L;
                    end else if (k.low_j) begin
                        n_len[LB_J] = 1'b1;
                    end else if (k.low_z) begin
                        n_len[LB_Z] = 1'b1;
                    end else if (k.up_l) begin
                        n_len[LB_BL] = 1'b1;
                    end else if (!k.skip) begin
                        fall_f2 = 1'b1;
                    end
                end
            end

            if (fall_f2) begin
                if (k.flag != '0) begin
                    n_flags = n_flags | k.flag;
                    n_phase = PH_FLAGS2;
                end else begin
                    emit = 1'b1;
                end
            end

            if (emit) begin
                fres = n_flags;
                if (fres[FB_MINUS]) fres[FB_ZERO]  = 1'b0;
                if (fres[FB_PLUS])  fres[FB_SPACE] = 1'b0;
                n_rec.conv_char       = i_item.ch;
                n_rec.flag_bits       = fres;
                n_rec.field_width     = n_width;
                n_rec.has_precision   = n_prec_seen;
                n_rec.precision_value = n_prec;
                n_rec.neg_star_prec   = n_neg_star;
                n_rec.length_bits     = n_len;
                n_rec.upper_conv      = k.upper;
                n_out_valid           = 1'b1;
                n_phase               = PH_FLAGS1;
                n_pend                = PEND_NONE;
                n_flags               = '0;
                n_width               = '0;
                n_prec                = '0;
                n_prec_seen           = 1'b0;
                n_neg_star            = 1'b0;
                n_len                 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAGS1;
            r_pend      <= PEND_NONE;
            r_flags     <= '0;
            r_width     <= '0;
            r_prec      <= '0;
            r_prec_seen <= 1'b0;
            r_neg_star  <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_flags     <= n_flags;
            r_width     <= n_width;
            r_prec      <= n_prec;
            r_prec_seen <= n_prec_seen;
            r_neg_star  <= n_neg_star;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.conv_char       = r_rec.conv_char;
    assign o_out.flag_bits       = r_rec.flag_bits;
    assign o_out.field_width     = r_rec.field_width;
    assign o_out.has_precision   = r_rec.has_precision;
    assign o_out.precision_value = r_rec.precision_value;
    assign o_out.neg_star_prec   = r_rec.neg_star_prec;
    assign o_out.length_bits     = r_rec.length_bits;
    assign o_out.upper_conv      = r_rec.upper_conv;

endmodule

// ----- rtl/format_spec_parser.sv -----
// top level of the format spec parser: front, beat queue and back
//
//  channel | dir | beat                          | handshake
//  i_in    | in  | char_byte, star_value         | valid/ready
//  o_out   | out | resolved spec record, 8 fields | valid/ready
//
// one beat per cycle sustained unless a record is held; a record leaves the
// cycle after its conversion byte leaves the two-entry queue.
// the back phase machine and its digit accumulators set the rate.
// reset is synchronous and clears phase, accumulators, queue and output valid.
// a held record stalls the back; the queue keeps taking beats until full.
module format_spec_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsp_in_if.sink    i_in,
    fsp_out_if.source o_out
);
    import fsp_pkg::*;

    t_item front_item;
    t_item q_item;
    logic  q_valid;
    logic  q_ready;

    fsp_front u_front (
        .i_char_byte  (i_in.char_byte),
        .i_star_value (i_in.star_value),
        .o_item       (front_item)
    );

    fsp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in.valid),
        .i_push_item  (front_item),
        .o_push_ready (i_in.ready),
        .o_pop_valid  (q_valid),
        .o_pop_item   (q_item),
        .i_pop_ready  (q_ready)
    );

    fsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_ready (q_ready),
        .o_out        (o_out)
    );

endmodule

// ----- rtl/fsp_checker.sv -----
// port-level checks for the format spec parser and their bind
module fsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_conv_char,
    input logic [4:0]  i_flag_bits,
    input logic        i_has_precision,
    input logic [30:0] i_precision_value,
    input logic        i_neg_star_prec,
    input logic        i_upper_conv
);
    import fsp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_conv_char))
        else $error("record dropped or changed while stalled");

    a_flag_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_flag_bits[FB_MINUS] && i_flag_bits[FB_ZERO])
                        && !(i_flag_bits[FB_PLUS] && i_flag_bits[FB_SPACE]))
        else $error("flags not resolved");

    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_upper_conv == ((i_conv_char >= CH_UP_A) && (i_conv_char <= CH_UP_Z)))
        else $error("upper flag mismatch");

    a_prec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (!i_has_precision || i_neg_star_prec) |->
            i_precision_value == '0 && (i_has_precision || !i_neg_star_prec))
        else $error("precision without a dot or negative star");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_conv_char       (o_out.conv_char),
    .i_flag_bits       (o_out.flag_bits),
    .i_has_precision   (o_out.has_precision),
    .i_precision_value (o_out.precision_value),
    .i_neg_star_prec   (o_out.neg_star_prec),
    .i_upper_conv      (o_out.upper_conv)
);
